/* design/refcounted_block_allocator_top_assert.svh */
// Assertion macros used by the allocator port-level checker.
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/refalloc_pkg.sv */
// Types, field widths and codes for the reference-counted block allocator.
`timescale 1ns / 1ps

package refalloc_pkg;

    localparam int POOL_SIZE_DEF  = 1024;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W          = 2;
    localparam int BLOCK_INDEX_W = 16;
    localparam int STATUS_W      = 3;
    localparam int GRANT_W       = 10;
    localparam int BLOCK_COUNT_W = 16;
    localparam int BLOCKS_W      = 11;
    localparam int ACTIVE_W      = 11;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_SHARE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FREE      = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef struct packed {
        logic clear_start;
        logic clear_step;
        logic accept;
        logic exec;
    } rba_cmd_t;

    typedef struct packed {
        logic clear_done;
    } rba_stat_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* design/refcounted_block_allocator_top.sv */
// Reference-counted block allocator: a pool of block ids on a LIFO free stack.
// Input channel (s_*): operation (allocate, share, release, query) and block_index.
// Result channel (m_*): status, granted_block, block_count, used_blocks and
// free_blocks_left; one result per input item, in order.
// Config channel (cfg_*): active_blocks, clamped to 1..POOL_SIZE; a write
// reinitializes the pool and is accepted in any cycle (cfg_ready is always high).
// Each item first reads the refcount and free-stack memories (registered
// read), then updates them and loads the result register. A new item is not
// accepted until the previous one has loaded its result.
// After reset and after every config write a clearing sweep over all POOL_SIZE
// entries zeroes the refcounts and refills the free stack; s_ready stays low
// until it ends. The first allocate then grants block 0.
// When the receiver stalls the result register holds; a new item is accepted
// in the cycle the pending result is taken, so nothing is lost.
`timescale 1ns / 1ps

module refcounted_block_allocator_top #(
    parameter int POOL_SIZE  = refalloc_pkg::POOL_SIZE_DEF,
    parameter int COUNT_BITS = refalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [refalloc_pkg::OP_W-1:0]           s_operation,
    input  logic [refalloc_pkg::BLOCK_INDEX_W-1:0]  s_block_index,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [refalloc_pkg::STATUS_W-1:0]       m_status,
    output logic [refalloc_pkg::GRANT_W-1:0]        m_granted_block,
    output logic [refalloc_pkg::BLOCK_COUNT_W-1:0]  m_block_count,
    output logic [refalloc_pkg::BLOCKS_W-1:0]       m_used_blocks,
    output logic [refalloc_pkg::BLOCKS_W-1:0]       m_free_blocks_left,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [refalloc_pkg::ACTIVE_W-1:0]       cfg_data
);
    import refalloc_pkg::*;

    rba_cmd_t  cmd;
    rba_stat_t stat;
    logic      cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    refalloc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cfg_fire (cfg_fire),
        .cmd      (cmd),
        .stat     (stat)
    );

    refalloc_datapath #(
        .POOL_SIZE  (POOL_SIZE),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_data           (cfg_data),
        .s_operation        (s_operation),
        .s_block_index      (s_block_index),
        .m_status           (m_status),
        .m_granted_block    (m_granted_block),
        .m_block_count      (m_block_count),
        .m_used_blocks      (m_used_blocks),
        .m_free_blocks_left (m_free_blocks_left)
    );

endmodule

/* design/refalloc_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module refalloc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [refalloc_pkg::addr_bits(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [refalloc_pkg::addr_bits(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]                           rdata
);
    import refalloc_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/refalloc_ctrl.sv */
// Controller: clearing sweep, item accept, execute and result handshake.
`timescale 1ns / 1ps

module refalloc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    cfg_fire,
    output refalloc_pkg::rba_cmd_t  cmd,
    input  refalloc_pkg::rba_stat_t stat
);
    import refalloc_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR: begin
                if (!cfg_fire) begin
                    cmd.clear_step = 1'b1;
                    if (stat.clear_done) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                s_ready = (!m_valid_reg || m_ready) && !cfg_fire;
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
        if (cfg_fire) begin
            cmd.clear_start = 1'b1;
            state_next      = S_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* design/refalloc_datapath.sv */
// Datapath: refcount and free-stack memories, pool counters, result register.
`timescale 1ns / 1ps

module refalloc_datapath #(
    parameter int POOL_SIZE  = refalloc_pkg::POOL_SIZE_DEF,
    parameter int COUNT_BITS = refalloc_pkg::COUNT_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  refalloc_pkg::rba_cmd_t                    cmd,
    output refalloc_pkg::rba_stat_t                   stat,
    input  logic [refalloc_pkg::ACTIVE_W-1:0]         cfg_data,
    input  logic [refalloc_pkg::OP_W-1:0]             s_operation,
    input  logic [refalloc_pkg::BLOCK_INDEX_W-1:0]    s_block_index,
    output logic [refalloc_pkg::STATUS_W-1:0]         m_status,
    output logic [refalloc_pkg::GRANT_W-1:0]          m_granted_block,
    output logic [refalloc_pkg::BLOCK_COUNT_W-1:0]    m_block_count,
    output logic [refalloc_pkg::BLOCKS_W-1:0]         m_used_blocks,
    output logic [refalloc_pkg::BLOCKS_W-1:0]         m_free_blocks_left
);
    import refalloc_pkg::*;

    localparam int ID_W  = addr_bits(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);
    localparam int CW_A  = (CNT_W > BLOCK_INDEX_W) ? CNT_W : BLOCK_INDEX_W;
    localparam int CMP_W = ((CW_A > ACTIVE_W) ? CW_A : ACTIVE_W) + 1;

    logic [CNT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [ID_W-1:0]  clr_reg, clr_next;
    op_t              op_reg;
    logic [ID_W-1:0]  id_reg;
    logic             range_bad_reg;

    logic [CMP_W-1:0] cfg_wide;
    logic [CNT_W-1:0] cfg_clamped;

    logic                  cnt_we, stk_we;
    logic [ID_W-1:0]       cnt_waddr, stk_waddr, cnt_raddr, stk_raddr;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic [ID_W-1:0]       stk_wdata, stk_rd;

    status_t               res_status;
    logic [ID_W-1:0]       res_grant;
    logic [COUNT_BITS-1:0] res_count;

    status_t                  status_reg;
    logic [GRANT_W-1:0]       grant_reg;
    logic [BLOCK_COUNT_W-1:0] count_reg;
    logic [BLOCKS_W-1:0]      used_out_reg, free_out_reg;

    always_comb begin
        cfg_wide = CMP_W'(cfg_data);
        if (cfg_wide == '0) begin
            cfg_clamped = CNT_W'(1);
        end else if (cfg_wide > CMP_W'(POOL_SIZE)) begin
            cfg_clamped = CNT_W'(POOL_SIZE);
        end else begin
            cfg_clamped = CNT_W'(cfg_wide);
        end
    end

    assign cnt_raddr       = ID_W'(s_block_index);
    assign stk_raddr       = ID_W'(depth_reg - CNT_W'(1));
    assign stat.clear_done = (clr_reg == ID_W'(POOL_SIZE - 1));

    always_comb begin
        active_next = active_reg;
        depth_next  = depth_reg;
        used_next   = used_reg;
        clr_next    = clr_reg;
        cnt_we      = 1'b0;
        cnt_waddr   = clr_reg;
        cnt_wdata   = '0;
        stk_we      = 1'b0;
        stk_waddr   = clr_reg;
        stk_wdata   = ID_W'(active_reg - CNT_W'(1) - CNT_W'(clr_reg));
        res_status  = ST_OK;
        res_grant   = '0;
        res_count   = '0;
        if (cmd.clear_start) begin
            active_next = cfg_clamped;
            depth_next  = cfg_clamped;
            used_next   = '0;
            clr_next    = '0;
        end else if (cmd.clear_step) begin
            cnt_we   = 1'b1;
            stk_we   = 1'b1;
            clr_next = clr_reg + ID_W'(1);
        end else if (cmd.exec) begin
            if (op_reg == OP_ALLOC) begin
                if (depth_reg == '0) begin
                    res_status = ST_EXHAUSTED;
                end else begin
                    depth_next = depth_reg - CNT_W'(1);
                    used_next  = used_reg + CNT_W'(1);
                    res_grant  = stk_rd;
                    res_count  = COUNT_BITS'(1);
                    cnt_we     = 1'b1;
                    cnt_waddr  = stk_rd;
                    cnt_wdata  = COUNT_BITS'(1);
                end
            end else if (range_bad_reg) begin
                res_status = ST_RANGE;
            end else if (op_reg == OP_QUERY) begin
                res_count = cnt_rd;
            end else if (cnt_rd == '0) begin
                res_status = ST_FREE;
            end else if (op_reg == OP_SHARE) begin
                if (cnt_rd == '1) begin
                    res_status = ST_SATURATED;
                    res_count  = cnt_rd;
                end else begin
                    res_count = cnt_rd + COUNT_BITS'(1);
                    cnt_we    = 1'b1;
                    cnt_waddr = id_reg;
                    cnt_wdata = res_count;
                end
            end else begin
                res_count = cnt_rd - COUNT_BITS'(1);
                cnt_we    = 1'b1;
                cnt_waddr = id_reg;
                cnt_wdata = res_count;
                // last reference gone: push the id back
                if (cnt_rd == COUNT_BITS'(1)) begin
                    stk_we     = 1'b1;
                    stk_waddr  = ID_W'(depth_reg);
                    stk_wdata  = id_reg;
                    depth_next = depth_reg + CNT_W'(1);
                    used_next  = used_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= CNT_W'(POOL_SIZE);
            depth_reg  <= CNT_W'(POOL_SIZE);
            used_reg   <= '0;
            clr_reg    <= '0;
        end else begin
            active_reg <= active_next;
            depth_reg  <= depth_next;
            used_reg   <= used_next;
            clr_reg    <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg        <= op_t'(s_operation);
            id_reg        <= ID_W'(s_block_index);
            range_bad_reg <= CMP_W'(s_block_index) >= CMP_W'(active_reg);
        end
        if (cmd.exec) begin
            status_reg   <= res_status;
            grant_reg    <= GRANT_W'(res_grant);
            count_reg    <= BLOCK_COUNT_W'(res_count);
            used_out_reg <= BLOCKS_W'(used_next);
            free_out_reg <= BLOCKS_W'(active_reg - used_next);
        end
    end

    refalloc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (POOL_SIZE)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    refalloc_ram #(
        .WIDTH (ID_W),
        .DEPTH (POOL_SIZE)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    assign m_status           = status_reg;
    assign m_granted_block    = grant_reg;
    assign m_block_count      = count_reg;
    assign m_used_blocks      = used_out_reg;
    assign m_free_blocks_left = free_out_reg;

endmodule

/* design/refalloc_checker.sv */
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "refcounted_block_allocator_top_assert.svh"

module refalloc_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic [refalloc_pkg::STATUS_W-1:0]       m_status,
    input logic [refalloc_pkg::GRANT_W-1:0]        m_granted_block,
    input logic [refalloc_pkg::BLOCK_COUNT_W-1:0]  m_block_count
);
    import refalloc_pkg::*;

    `RBA_ASSERT_NOW(a_grant_only_on_ok, aclk, aresetn,
        m_valid && (m_status != ST_OK), m_granted_block == '0, "grant on failed item")

    `RBA_ASSERT_NOW(a_count_zero_on_error, aclk, aresetn,
        m_valid && (m_status == ST_EXHAUSTED || m_status == ST_RANGE || m_status == ST_FREE),
        m_block_count == '0, "nonzero count on error status")

    `RBA_ASSERT_NEXT(a_two_cycle_item, aclk, aresetn,
        s_valid && s_ready, !s_ready, "item accepted in back-to-back cycles")

    `RBA_ASSERT_NEXT(a_result_holds, aclk, aresetn,
        m_valid && !m_ready, m_valid && $stable(m_status), "stalled result changed")

endmodule

bind refcounted_block_allocator_top refalloc_checker u_checker (.*);

/* sim/refalloc_checker.sv */
// Checker for the block allocator: predicts each result from the requests seen and compares.
`timescale 1ns / 1ps

module refalloc_scoreboard #(
    parameter int POOL_SIZE = refalloc_pkg::POOL_SIZE_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [refalloc_pkg::OP_W-1:0]           s_operation,
    input  logic [refalloc_pkg::BLOCK_INDEX_W-1:0]  s_block_index,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [refalloc_pkg::STATUS_W-1:0]       m_status,
    input  logic [refalloc_pkg::GRANT_W-1:0]        m_granted_block,
    input  logic [refalloc_pkg::BLOCK_COUNT_W-1:0]  m_block_count,
    input  logic [refalloc_pkg::BLOCKS_W-1:0]       m_used_blocks,
    input  logic [refalloc_pkg::BLOCKS_W-1:0]       m_free_blocks_left,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [refalloc_pkg::ACTIVE_W-1:0]       cfg_data,
    output int                                      mismatch_total,
    output int                                      results_owed
);
    import refalloc_pkg::*;

    typedef struct packed {
        status_t                  status;
        logic [GRANT_W-1:0]       granted;
        logic [BLOCK_COUNT_W-1:0] count;
        logic [BLOCKS_W-1:0]      used;
        logic [BLOCKS_W-1:0]      free_left;
    } alloc_result_t;

    localparam logic [BLOCK_COUNT_W-1:0] COUNT_MAX = '1;

    logic [BLOCK_COUNT_W-1:0] ref_count [POOL_SIZE];
    logic [GRANT_W-1:0]       free_ids  [POOL_SIZE];
    logic [ACTIVE_W-1:0]      free_depth;
    logic [ACTIVE_W-1:0]      used_now;
    logic [ACTIVE_W-1:0]      pool_blocks;

    alloc_result_t owed_results [$];
    int mismatch_count = 0;
    int results_seen   = 0;

    initial begin
        mismatch_total = 0;
        results_owed   = 0;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    // Clamp the requested size, clear counts, refill the stack with block 0 on top.
    function automatic void load_pool(input logic [ACTIVE_W-1:0] size);
        if (size == 0)
            pool_blocks = 1;
        else if (size > POOL_SIZE)
            pool_blocks = ACTIVE_W'(POOL_SIZE);
        else
            pool_blocks = size;
        for (int i = 0; i < POOL_SIZE; i++) begin
            ref_count[i] = '0;
            free_ids[i]  = (i < pool_blocks) ? GRANT_W'(pool_blocks - 1 - i) : '0;
        end
        free_depth = pool_blocks;
        used_now   = '0;
    endfunction

    function automatic alloc_result_t apply_request(input op_t op,
                                                    input logic [BLOCK_INDEX_W-1:0] id);
        alloc_result_t r;
        logic [GRANT_W-1:0] blk;
        r = '0;
        r.status = ST_OK;
        blk = id[GRANT_W-1:0];
        if (op == OP_ALLOC) begin
            if (free_depth == 0) begin
                r.status = ST_EXHAUSTED;
            end else begin
                free_depth--;
                r.granted = free_ids[free_depth];
                ref_count[r.granted] = 1;
                used_now++;
                r.count = 1;
            end
        end else if (id >= pool_blocks) begin
            r.status = ST_RANGE;
        end else if (op == OP_QUERY) begin
            r.count = ref_count[blk];
        end else if (ref_count[blk] == 0) begin
            r.status = ST_FREE;
        end else if (op == OP_SHARE) begin
            if (ref_count[blk] == COUNT_MAX)
                r.status = ST_SATURATED;
            else
                ref_count[blk]++;
            r.count = ref_count[blk];
        end else begin
            ref_count[blk]--;
            if (ref_count[blk] == 0) begin
                if (free_depth < POOL_SIZE) begin
                    free_ids[free_depth] = blk;
                    free_depth++;
                end
                if (used_now > 0)
                    used_now--;
            end
            r.count = ref_count[blk];
        end
        r.used      = used_now;
        r.free_left = pool_blocks - used_now;
        return r;
    endfunction

    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t predicted;
        if (!aresetn) begin
            load_pool(ACTIVE_W'(POOL_SIZE));
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    log_mismatch($sformatf("result with nothing outstanding (status %0d)",
                                           m_status));
                end else begin
                    want = owed_results.pop_front();
                    if (m_status !== want.status)
                        log_mismatch($sformatf("status %0d, want %0d", m_status, want.status));
                    if (m_granted_block !== want.granted)
                        log_mismatch($sformatf("granted_block %0d, want %0d",
                                               m_granted_block, want.granted));
                    if (m_block_count !== want.count)
                        log_mismatch($sformatf("block_count %0d, want %0d",
                                               m_block_count, want.count));
                    if (m_used_blocks !== want.used)
                        log_mismatch($sformatf("used_blocks %0d, want %0d",
                                               m_used_blocks, want.used));
                    if (m_free_blocks_left !== want.free_left)
                        log_mismatch($sformatf("free_blocks_left %0d, want %0d",
                                               m_free_blocks_left, want.free_left));
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready)
                load_pool(cfg_data);
            if (s_valid && s_ready) begin
                predicted    = apply_request(op_t'(s_operation), s_block_index);
                owed_results = {owed_results, predicted};
            end
        end
        results_owed   <= owed_results.size();
        mismatch_total <= mismatch_count;
    end

endmodule

/* sim/tb_refcounted_block_allocator_top.sv */
// Testbench top for the block allocator: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps

module tb_refcounted_block_allocator_top;
    import refalloc_pkg::*;

    localparam int POOL_MAX    = POOL_SIZE_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_operation;
    logic [BLOCK_INDEX_W-1:0] s_block_index;
    logic                     m_valid;
    logic                     m_ready;
    logic [STATUS_W-1:0]      m_status;
    logic [GRANT_W-1:0]       m_granted_block;
    logic [BLOCK_COUNT_W-1:0] m_block_count;
    logic [BLOCKS_W-1:0]      m_used_blocks;
    logic [BLOCKS_W-1:0]      m_free_blocks_left;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [ACTIVE_W-1:0]      cfg_data;
    int                       mismatch_total;
    int                       results_owed;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int recv_hold      = 0;
    int pool_size      = POOL_MAX;
    int cycle_count    = 0;

    refcounted_block_allocator_top i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_block_index      (s_block_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_granted_block    (m_granted_block),
        .m_block_count      (m_block_count),
        .m_used_blocks      (m_used_blocks),
        .m_free_blocks_left (m_free_blocks_left),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data)
    );

    refalloc_scoreboard i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Valid stays high across back-to-back items; it only drops in an idle gap.
    task automatic send_item(input op_t op, input logic [BLOCK_INDEX_W-1:0] id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_block_index <= id;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    task automatic write_pool_size(input logic [ACTIVE_W-1:0] value);
        drain_results();
        while (!s_ready) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == 0)
            pool_size = 1;
        else if (value > POOL_MAX)
            pool_size = POOL_MAX;
        else
            pool_size = value;
    endtask

    // Mostly ids near the bottom of the pool, where held blocks live; some fully random.
    task automatic send_random_items(input int n);
        int unsigned pick;
        int span;
        op_t op;
        logic [BLOCK_INDEX_W-1:0] id;
        span = (pool_size < 24) ? pool_size : 24;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            op = (pick < 35) ? OP_ALLOC : (pick < 55) ? OP_SHARE :
                 (pick < 85) ? OP_RELEASE : OP_QUERY;
            if ($urandom_range(0, 9) == 0)
                id = BLOCK_INDEX_W'($urandom);
            else
                id = BLOCK_INDEX_W'($urandom_range(0, span));
            send_item(op, id);
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_operation   <= OP_ALLOC;
        s_block_index <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // full pool from reset
        send_item(OP_QUERY, 16'd0);
        send_item(OP_SHARE, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_ALLOC, 16'hFFFF);
        send_item(OP_ALLOC, 16'd0);
        send_item(OP_SHARE, 16'd0);
        send_item(OP_QUERY, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_ALLOC, 16'd5);
        send_item(OP_SHARE, 16'd1023);
        send_item(OP_QUERY, 16'd1023);
        send_item(OP_QUERY, 16'd1024);
        send_item(OP_SHARE, 16'hFFFF);
        send_item(OP_RELEASE, 16'hAAAA);
        send_item(OP_QUERY, 16'h5555);

        // zero clamps to a one-block pool
        write_pool_size(11'd0);
        send_item(OP_ALLOC, 16'd0);
        send_item(OP_ALLOC, 16'd0);
        send_item(OP_QUERY, 16'd1);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_ALLOC, 16'd0);

        // oversize clamps to the full pool
        write_pool_size(11'h7FF);
        send_item(OP_ALLOC, 16'd0);
        send_item(OP_RELEASE, 16'd1023);
        send_item(OP_QUERY, 16'd1023);
        send_item(OP_QUERY, 16'd1024);
        send_item(OP_ALLOC, 16'd0);

        // several references on one block, then drop them all
        write_pool_size(ACTIVE_W'(POOL_MAX));
        send_item(OP_ALLOC, 16'd0);
        send_item(OP_SHARE, 16'd0);
        send_item(OP_SHARE, 16'd0);
        send_item(OP_QUERY, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_RELEASE, 16'd0);
        send_item(OP_SHARE, 16'd0);

        write_pool_size(11'd4);
        send_random_items(100);

        send_idle_pct = 87;
        write_pool_size(11'd9);
        send_random_items(80);

        send_idle_pct  = 0;
        recv_stall_pct = 87;
        write_pool_size(11'd16);
        send_random_items(80);

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        write_pool_size(ACTIVE_W'($urandom_range(1, POOL_MAX)));
        send_random_items(80);

        // receiver holds off while items keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_pool_size(11'd1025);
        recv_hold = 300;
        send_random_items(60);

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        write_pool_size(11'd3);
        send_random_items(50);

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_total == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/refalloc_pkg.sv
design/refalloc_ram.sv
design/refalloc_ctrl.sv
design/refalloc_datapath.sv
design/refcounted_block_allocator_top.sv
design/refalloc_checker.sv
sim/refalloc_checker.sv
sim/tb_refcounted_block_allocator_top.sv
